// ===== src/lpr_pkg.sv =====
// Shared types, constants and helper functions of the log pointer recover and record writer.
package lpr_pkg;

    localparam int unsigned ADDR_W = 18;
    localparam int unsigned PERIOD_W = 15;
    localparam int unsigned INTERVAL_W = 10;
    localparam int unsigned QUOT_W = 11;
    localparam int unsigned REC_W = 64;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam int unsigned LOG_START_DEF = 1024;
    localparam int unsigned LOG_END_DEF = 131072;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd30;
    // Battery-hour interval for the reset period of 30 seconds (28800 / 30).
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd960;
    localparam logic [INTERVAL_W-1:0] HOUR_UNITS = 10'd960;
    // floor(period / 30) == (period * RECIP_30) >> RECIP_SHIFT for every 15-bit period.
    localparam logic [15:0] RECIP_30 = 16'd34953;
    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned PROD_W = PERIOD_W + 16;

    localparam logic [7:0] BYTE_ERASED = 8'hFF;
    localparam logic [7:0] BYTE_CAPPED = 8'hFE;
    localparam logic [REC_W-1:0] MARK_RECORD = 64'hFEFE_0000_FEFE_0000;

    localparam logic [4:0] MOD_LAST_STEP = 5'(ADDR_W - 1);
    localparam logic [3:0] DIV_LAST_STEP = 4'(INTERVAL_W - 1);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_REPLY = 2'd1,
        OP_LOG   = 2'd2,
        OP_MARK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_READ      = 2'd0,
        K_WRITE     = 2'd1,
        K_RECOVERED = 2'd2,
        K_FULL      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_MID  = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        EM_NONE   = 3'd0,
        EM_START  = 3'd1,
        EM_PH1    = 3'd2,
        EM_SEARCH = 3'd3,
        EM_FULL   = 3'd4,
        EM_BYTE   = 3'd5
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  resolve;
        logic  mod_step;
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        t_op    op;
        t_phase phase;
        logic   full;
        logic   mod_last;
        logic   byte_last;
        logic   slot_free;
    } t_dp_stat;

    // High byte of a sample; an all-ones byte is stored as 0xFE.
    function automatic logic [7:0] cap_high(input logic [15:0] v);
        logic [7:0] h;
        h = v[15:8];
        return (h == BYTE_ERASED) ? BYTE_CAPPED : h;
    endfunction

    // Even midpoint of the search window: 2 * ((low + high) / 4).
    function automatic logic [ADDR_W-1:0] midpoint(input logic [ADDR_W-1:0] lo,
                                                   input logic [ADDR_W-1:0] hi);
        logic [ADDR_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return {sum[ADDR_W:2], 1'b0};
    endfunction

endpackage

// ===== src/lpr_if.sv =====
// Request and result channel interfaces of the log pointer recover and record writer.
interface lpr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  read_byte;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] activity;
    logic        range_flag;

    modport source (
        output valid, operation, read_byte, red, green, blue, activity, range_flag,
        input  ready
    );
    modport sink (
        input  valid, operation, read_byte, red, green, blue, activity, range_flag,
        output ready
    );
endinterface

interface lpr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        bus_device;
    logic [15:0] bus_offset;
    logic [7:0]  write_data;
    logic        hour_due;
    logic [17:0] pointer;
    logic        last;

    modport source (
        output valid, kind, bus_device, bus_offset, write_data, hour_due, pointer, last,
        input  ready
    );
    modport sink (
        input  valid, kind, bus_device, bus_offset, write_data, hour_due, pointer, last,
        output ready
    );
endinterface

// ===== src/lpr_cfg.sv =====
// Period register with its APB port and the serial divider that derives the battery-hour interval.
module lpr_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lpr_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [lpr_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [lpr_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    output logic                                 o_busy,
    output logic [lpr_pkg::INTERVAL_W-1:0]       o_interval
);
    import lpr_pkg::*;

    logic [PERIOD_W-1:0]   r_log_period, n_log_period;
    logic [INTERVAL_W-1:0] r_interval, n_interval;
    logic                  r_busy, n_busy;
    logic                  r_mul, n_mul;
    logic [3:0]            r_step, n_step;
    logic [QUOT_W-1:0]     r_div, n_div;
    logic [QUOT_W-1:0]     r_rem, n_rem;
    logic [INTERVAL_W-1:0] r_dvd, n_dvd;
    logic [INTERVAL_W-1:0] r_quo, n_quo;

    logic                  w_sel0;
    logic                  w_write;
    logic [PROD_W-1:0]     w_prod;
    logic [QUOT_W-1:0]     w_q;
    logic [QUOT_W:0]       w_rem_sh;
    logic                  w_bit;
    logic [INTERVAL_W-1:0] w_quo;

    // Only the register at index zero exists; address bit 2 selects the register index.
    assign w_sel0  = (paddr[2] == 1'b0);
    assign w_write = psel && penable && pwrite && w_sel0;
    assign pready  = 1'b1;
    assign prdata  = w_sel0 ? {{(APB_DATA_W-PERIOD_W){1'b0}}, r_log_period} : '0;

    assign w_prod   = PROD_W'(r_log_period) * PROD_W'(RECIP_30);
    assign w_q      = w_prod[PROD_W-1:RECIP_SHIFT];
    assign w_rem_sh = {r_rem, r_dvd[INTERVAL_W-1]};
    assign w_bit    = (w_rem_sh >= {1'b0, r_div});
    assign w_quo    = {r_quo[INTERVAL_W-2:0], w_bit};

    always_comb begin
        n_log_period = r_log_period;
        n_interval   = r_interval;
        n_busy       = r_busy;
        n_mul        = r_mul;
        n_step       = r_step;
        n_div        = r_div;
        n_rem        = r_rem;
        n_dvd        = r_dvd;
        n_quo        = r_quo;
        if (w_write) begin
            n_log_period = pwdata[PERIOD_W-1:0];
            n_busy       = 1'b1;
            n_mul        = 1'b1;
        end else if (r_busy && r_mul) begin
            // Periods below 30 count as 30, so the divisor is at least one.
            n_div  = (w_q == '0) ? QUOT_W'(1) : w_q;
            n_mul  = 1'b0;
            n_step = '0;
            n_rem  = '0;
            n_dvd  = HOUR_UNITS;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem  = w_bit ? QUOT_W'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[QUOT_W-1:0];
            n_dvd  = {r_dvd[INTERVAL_W-2:0], 1'b0};
            n_quo  = w_quo;
            n_step = r_step + 4'd1;
            if (r_step == DIV_LAST_STEP) begin
                n_busy     = 1'b0;
                n_interval = (w_quo == '0) ? INTERVAL_W'(1) : w_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_period <= PERIOD_RESET;
            r_interval   <= INTERVAL_RESET;
            r_busy       <= 1'b0;
            r_mul        <= 1'b0;
            r_step       <= '0;
        end else begin
            r_log_period <= n_log_period;
            r_interval   <= n_interval;
            r_busy       <= n_busy;
            r_mul        <= n_mul;
            r_step       <= n_step;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
    end

    assign o_busy     = r_busy;
    assign o_interval = r_interval;

endmodule

// ===== src/lpr_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module lpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cfg_busy,
    input  lpr_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output lpr_pkg::t_dp_cmd  o_cmd
);
    import lpr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_START    = 9'b000000100,
        S_PH1      = 9'b000001000,
        S_RESOLVE  = 9'b000010000,
        S_FINISH   = 9'b000100000,
        S_FULL     = 9'b001000000,
        S_MOD      = 9'b010000000,
        S_BYTES    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{capture: 1'b0, resolve: 1'b0, mod_step: 1'b0, emit: EM_NONE};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_cfg_busy;
                if (i_in_valid && !i_cfg_busy) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    OP_START: n_state = S_START;
                    OP_REPLY: begin
                        if (i_stat.phase == PH_MID) begin
                            n_state = S_PH1;
                        end else if (i_stat.phase == PH_LOW) begin
                            n_state = S_RESOLVE;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    OP_LOG:   n_state = i_stat.full ? S_FULL : S_MOD;
                    OP_MARK:  n_state = i_stat.full ? S_FULL : S_BYTES;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_START: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = EM_START;
                    n_state    = S_IDLE;
                end
            end
            S_PH1: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = EM_PH1;
                    n_state    = S_IDLE;
                end
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = EM_SEARCH;
                    n_state    = S_IDLE;
                end
            end
            S_FULL: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = EM_FULL;
                    n_state    = S_IDLE;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_BYTES;
                end
            end
            S_BYTES: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = EM_BYTE;
                    if (i_stat.byte_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/lpr_dp.sv =====
// Datapath: pointer and search registers, record packing, pointer modulo unit and result register.
module lpr_dp #(
    parameter int unsigned LOG_START = lpr_pkg::LOG_START_DEF,
    parameter int unsigned LOG_END   = lpr_pkg::LOG_END_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lpr_pkg::t_dp_cmd               i_cmd,
    input  logic [lpr_pkg::INTERVAL_W-1:0] i_interval,
    output lpr_pkg::t_dp_stat              o_stat,
    lpr_req_if.sink                        i_req,
    lpr_res_if.source                      o_res
);
    import lpr_pkg::*;

    localparam logic [ADDR_W-1:0] START_A = ADDR_W'(LOG_START);
    localparam logic [ADDR_W-1:0] END_A   = ADDR_W'(LOG_END);
    localparam logic [ADDR_W-1:0] LIMIT_A = ADDR_W'(LOG_END - 8);
    localparam logic [ADDR_W-1:0] MID0_A  = midpoint(START_A, END_A);

    // Search and pointer state.
    logic [ADDR_W-1:0]     r_wp, n_wp;
    logic [ADDR_W-1:0]     r_low, n_low;
    logic [ADDR_W-1:0]     r_high, n_high;
    logic [ADDR_W-1:0]     r_probe, n_probe;
    logic [7:0]            r_pv, n_pv;
    t_phase                r_phase, n_phase;
    // Per-request working registers.
    t_op                   r_op, n_op;
    logic [7:0]            r_rb, n_rb;
    logic [REC_W-1:0]      r_rec, n_rec;
    logic [2:0]            r_idx, n_idx;
    logic [4:0]            r_mcnt, n_mcnt;
    logic [ADDR_W-1:0]     r_msh, n_msh;
    logic [INTERVAL_W-1:0] r_rem, n_rem;
    logic                  r_found, n_found;
    logic [ADDR_W-1:0]     r_aw, n_aw;
    // Result register.
    logic                  r_ov, n_ov;
    t_kind                 r_kind, n_kind;
    logic                  r_dev, n_dev;
    logic [15:0]           r_off, n_off;
    logic [7:0]            r_data, n_data;
    logic                  r_hour, n_hour;
    logic [ADDR_W-1:0]     r_ptr, n_ptr;
    logic                  r_last, n_last;

    logic                  w_slot_free;
    logic [15:0]           w_act;
    logic [REC_W-1:0]      w_rec;
    logic [INTERVAL_W:0]   w_rem_sh;
    logic [ADDR_W-1:0]     w_mid;
    logic [ADDR_W-1:0]     w_al;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [ADDR_W-1:0]     w_wp_next;
    logic                  w_full;

    assign w_slot_free = !r_ov || o_res.ready;
    assign w_act = {i_req.activity[15:1], i_req.range_flag};
    assign w_rec = (t_op'(i_req.operation) == OP_MARK) ? MARK_RECORD :
                   {cap_high(i_req.red), i_req.red[7:0],
                    cap_high(i_req.green), i_req.green[7:0],
                    cap_high(i_req.blue), i_req.blue[7:0],
                    cap_high(w_act), w_act[7:0]};

    assign w_rem_sh  = {r_rem, r_msh[ADDR_W-1]};
    assign w_mid     = midpoint(r_low, r_high);
    assign w_al      = ({r_aw[ADDR_W-1:3], 3'b000} <= START_A) ? START_A
                                                             : {r_aw[ADDR_W-1:3], 3'b000};
    assign w_rd_addr = r_probe - ADDR_W'(2);
    assign w_wr_addr = r_wp + ADDR_W'(r_idx);
    assign w_wp_next = r_wp + ADDR_W'(8);
    assign w_full    = ({1'b0, r_wp} + (ADDR_W+1)'(8)) > (ADDR_W+1)'(LOG_END);

    always_comb begin
        n_wp    = r_wp;
        n_low   = r_low;
        n_high  = r_high;
        n_probe = r_probe;
        n_pv    = r_pv;
        n_phase = r_phase;
        n_op    = r_op;
        n_rb    = r_rb;
        n_rec   = r_rec;
        n_idx   = r_idx;
        n_mcnt  = r_mcnt;
        n_msh   = r_msh;
        n_rem   = r_rem;
        n_found = r_found;
        n_aw    = r_aw;
        n_ov    = r_ov && !o_res.ready;
        n_kind  = r_kind;
        n_dev   = r_dev;
        n_off   = r_off;
        n_data  = r_data;
        n_hour  = r_hour;
        n_ptr   = r_ptr;
        n_last  = r_last;

        if (i_cmd.capture) begin
            n_op   = t_op'(i_req.operation);
            n_rb   = i_req.read_byte;
            n_rec  = w_rec;
            n_idx  = '0;
            n_mcnt = '0;
            n_msh  = r_wp;
            n_rem  = '0;
        end

        // One restoring step of write_pointer modulo interval, most significant bit first.
        if (i_cmd.mod_step) begin
            n_rem  = (w_rem_sh >= {1'b0, i_interval})
                   ? INTERVAL_W'(w_rem_sh - {1'b0, i_interval}) : w_rem_sh[INTERVAL_W-1:0];
            n_msh  = {r_msh[ADDR_W-2:0], 1'b0};
            n_mcnt = r_mcnt + 5'd1;
        end

        // Evaluate both probe bytes and narrow the window.
        if (i_cmd.resolve) begin
            n_found = 1'b0;
            n_aw    = r_probe;
            if (r_pv == BYTE_ERASED && r_rb != BYTE_ERASED) begin
                n_found = 1'b1;
            end else if (r_pv == BYTE_ERASED && r_probe > START_A) begin
                n_high = {r_probe[ADDR_W-1:1], 1'b0};
            end else if (r_probe <= START_A) begin
                n_aw    = START_A;
                n_found = 1'b1;
            end else begin
                n_low = {r_probe[ADDR_W-1:1], 1'b0};
            end
            if (n_aw >= LIMIT_A) begin
                n_found = 1'b1;
            end
        end

        if (i_cmd.emit != EM_NONE) begin
            n_ov   = 1'b1;
            n_kind = K_READ;
            n_dev  = 1'b0;
            n_off  = '0;
            n_data = '0;
            n_hour = 1'b0;
            n_ptr  = r_wp;
            n_last = 1'b1;
        end

        unique case (i_cmd.emit)
            EM_NONE: begin
            end
            EM_START: begin
                n_low   = START_A;
                n_high  = END_A;
                n_probe = MID0_A;
                n_phase = PH_MID;
                n_dev   = |MID0_A[ADDR_W-1:16];
                n_off   = MID0_A[15:0];
            end
            EM_PH1: begin
                n_pv    = r_rb;
                n_phase = PH_LOW;
                n_dev   = |w_rd_addr[ADDR_W-1:16];
                n_off   = w_rd_addr[15:0];
            end
            EM_SEARCH: begin
                if (!r_found && w_mid != r_aw) begin
                    n_probe = w_mid;
                    n_phase = PH_MID;
                    n_dev   = |w_mid[ADDR_W-1:16];
                    n_off   = w_mid[15:0];
                end else begin
                    n_wp    = w_al;
                    n_probe = w_al;
                    n_phase = PH_IDLE;
                    n_kind  = K_RECOVERED;
                    n_ptr   = w_al;
                end
            end
            EM_FULL: begin
                n_kind = K_FULL;
            end
            EM_BYTE: begin
                n_kind = K_WRITE;
                n_dev  = |w_wr_addr[ADDR_W-1:16];
                n_off  = w_wr_addr[15:0];
                n_data = r_rec[REC_W-1 -: 8];
                n_hour = (r_op == OP_LOG) && (r_idx == '0) && (r_rem == '0);
                n_ptr  = w_wp_next;
                n_last = (r_idx == 3'd7);
                n_rec  = {r_rec[REC_W-9:0], 8'h00};
                n_idx  = r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    n_wp = w_wp_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_low   <= START_A;
            r_high  <= END_A;
            r_probe <= '0;
            r_pv    <= '0;
            r_phase <= PH_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_wp    <= n_wp;
            r_low   <= n_low;
            r_high  <= n_high;
            r_probe <= n_probe;
            r_pv    <= n_pv;
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
        r_op    <= n_op;
        r_rb    <= n_rb;
        r_rec   <= n_rec;
        r_idx   <= n_idx;
        r_mcnt  <= n_mcnt;
        r_msh   <= n_msh;
        r_rem   <= n_rem;
        r_found <= n_found;
        r_aw    <= n_aw;
        r_kind  <= n_kind;
        r_dev   <= n_dev;
        r_off   <= n_off;
        r_data  <= n_data;
        r_hour  <= n_hour;
        r_ptr   <= n_ptr;
        r_last  <= n_last;
    end

    assign o_stat = '{op: r_op, phase: r_phase, full: w_full,
                      mod_last: (r_mcnt == MOD_LAST_STEP),
                      byte_last: (r_idx == 3'd7), slot_free: w_slot_free};

    assign o_res.valid      = r_ov;
    assign o_res.kind       = r_kind;
    assign o_res.bus_device = r_dev;
    assign o_res.bus_offset = r_off;
    assign o_res.write_data = r_data;
    assign o_res.hour_due   = r_hour;
    assign o_res.pointer    = r_ptr;
    assign o_res.last       = r_last;

endmodule

// ===== src/log_pointer_recover_and_record_writer_core.sv =====
// Top level of the log pointer recover and record writer: controller, datapath and period register.
// Sequence: each request passes the dispatch state; a start or reply then loads its result into
// the output register once the output slot is free (a closing reply after the resolve state);
// a mark writes one byte per cycle while results flow; a log first runs bit-serial pointer modulo.
// Throughput: one request at a time; the next is accepted once the last result is loaded.
// Reset (synchronous, active low) clears the pointer and the search state and sets the period
// to 30 s; a period write keeps the request channel stalled while the interval divider runs.
module log_pointer_recover_and_record_writer_core #(
    parameter int unsigned LOG_START = lpr_pkg::LOG_START_DEF,
    parameter int unsigned LOG_END   = lpr_pkg::LOG_END_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lpr_req_if.sink                          i_req,
    lpr_res_if.source                        o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lpr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lpr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lpr_pkg::*;

    t_dp_cmd               w_cmd;
    t_dp_stat              w_stat;
    logic                  w_in_ready;
    logic                  w_cfg_busy;
    logic [INTERVAL_W-1:0] w_interval;

    // The period register also owns the divider that turns the period into the number of
    // bytes between battery-hour marks; requests wait while it runs.
    lpr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_busy     (w_cfg_busy),
        .o_interval (w_interval)
    );

    // The controller decides the order of work; the datapath holds every value.
    lpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_cfg_busy (w_cfg_busy),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    lpr_dp #(
        .LOG_START (LOG_START),
        .LOG_END   (LOG_END)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_interval (w_interval),
        .o_stat     (w_stat),
        .i_req      (i_req),
        .o_res      (o_res)
    );

    // A request is taken only while the controller idles and no period update is pending.
    assign i_req.ready = w_in_ready;

endmodule

// ===== tb/sv/tb_log_pointer_recover_and_record_writer_core.sv =====
// Self-checking testbench for the log pointer recover and record writer core.
module tb_log_pointer_recover_and_record_writer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned LOG_START     = LOG_START_DEF;
    localparam int unsigned LOG_END       = LOG_END_DEF;
    localparam int unsigned ADDR_MASK     = (1 << ADDR_W) - 1;
    localparam int unsigned DEV1_BASE     = 65536;
    localparam int unsigned PERIOD_STEP   = 30;
    localparam int unsigned BATTERY_SPAN  = 28800;
    localparam int unsigned RECORD_BYTES  = 8;
    // A log request is the slowest one, so this covers any work still in flight.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned PROBE_REPLIES = 48;

    localparam logic [APB_ADDR_W-1:0] ADDR_LOG_PERIOD = '0;

    // One phase per period setting; the configuration is only touched between phases.
    localparam int unsigned NUM_PHASES     = 8;
    localparam int unsigned PHASE_UNITS    = 44;
    localparam int unsigned HOLD_PHASE     = 2;
    localparam int unsigned RANDOM_PERIOD  = 6;
    localparam logic [PERIOD_W-1:0] PHASE_PERIODS [NUM_PHASES] =
        '{15'd30, 15'd28800, 15'd32767, 15'd0, 15'd45, 15'd3600, 15'd900, 15'd29};
    // Idle odds out of 16 per cycle; a zero gives a stretch with no idling at all.
    localparam int unsigned SEND_ODDS [NUM_PHASES] = '{4, 6, 2, 0, 8, 3, 5, 0};
    localparam int unsigned RECV_ODDS [NUM_PHASES] = '{5, 3, 6, 4, 0, 8, 2, 0};

    // A request as the stimulus holds it. Replies marked from_memory take their byte from a
    // modeled memory image at the moment they are offered, so that the search sees a log
    // whose first erased byte lies at erased_from.
    typedef struct {
        t_op         op;
        logic [7:0]  reply_byte;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] activity;
        logic        range_flag;
        bit          from_memory;
        int unsigned erased_from;
    } t_request;

    typedef struct packed {
        t_kind       kind;
        logic        device;
        logic [15:0] offset;
        logic [7:0]  data;
        logic        hour_due;
        logic [17:0] pointer;
        logic        last;
    } t_bus_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lpr_req_if req_ch ();
    lpr_res_if res_ch ();

    log_pointer_recover_and_record_writer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Pending requests for the driver and the bus results the writer still owes us.
    t_request    request_q [$];
    t_bus_result result_q [$];

    // Shadow of the writer: pointer, search window and the period it was last given.
    logic [ADDR_W-1:0]   write_ptr   = '0;
    logic [ADDR_W-1:0]   srch_lo     = ADDR_W'(LOG_START);
    logic [ADDR_W-1:0]   srch_hi     = ADDR_W'(LOG_END);
    logic [ADDR_W-1:0]   probe_addr  = '0;
    logic [7:0]          probe_byte  = '0;
    t_phase              srch_phase  = PH_IDLE;
    logic [PERIOD_W-1:0] period_setting = PERIOD_RESET;

    // Handshake bookkeeping and idling controls shared by the driving processes.
    bit          req_fire;
    int unsigned send_odds;
    int unsigned recv_odds;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_left;
    bit          hold_armed;
    bit          hold_done;
    int unsigned fail_count;
    int unsigned cycle_count;
    t_request    held_req;

    // The search window midpoint, always even.
    function automatic logic [ADDR_W-1:0] window_mid(input logic [ADDR_W-1:0] lo,
                                                     input logic [ADDR_W-1:0] hi);
        int unsigned sum;
        sum = int'(lo) + int'(hi);
        return ADDR_W'((2 * (sum / 4)) & ADDR_MASK);
    endfunction

    // Stored high byte of a sample: an all-ones byte would read as erased, so it is capped.
    function automatic logic [7:0] capped_high(input logic [15:0] v);
        return (v[15:8] == BYTE_ERASED) ? BYTE_CAPPED : v[15:8];
    endfunction

    // Build one bus result; absolute addresses beyond the first device map to device 1.
    function automatic t_bus_result bus_result(input t_kind k, input int unsigned addr,
                                               input bit use_addr, input logic [7:0] data,
                                               input bit hour);
        t_bus_result r;
        int unsigned a;
        a = addr & ADDR_MASK;
        r = '0;
        r.kind = k;
        r.data = data;
        r.hour_due = hour;
        if (use_addr) begin
            if (a >= DEV1_BASE) begin
                r.device = 1'b1;
                r.offset = 16'(a - DEV1_BASE);
            end else begin
                r.offset = 16'(a);
            end
        end
        return r;
    endfunction

    function automatic string show(input t_bus_result r);
        return $sformatf("kind=%0d dev=%0d off=%h data=%h hour=%0d ptr=%0d last=%0d",
                         r.kind, r.device, r.offset, r.data, r.hour_due, r.pointer, r.last);
    endfunction

    // Advance the shadow writer by one accepted request and queue the results it owes.
    task automatic advance_writer(input t_request rq);
        t_bus_result step_q [$];
        logic [7:0]  rec [RECORD_BYTES];
        logic [15:0] act;
        int unsigned a;
        int unsigned m;
        int unsigned p;
        int unsigned interval;
        int unsigned wp;
        bit          found;
        bit          do_record;
        bit          hour;
        do_record = 1'b0;
        hour = 1'b0;
        case (rq.op)
            OP_START: begin
                // A start always reopens the whole log area, even in the middle of a search.
                srch_lo = ADDR_W'(LOG_START);
                srch_hi = ADDR_W'(LOG_END);
                probe_addr = window_mid(srch_lo, srch_hi);
                srch_phase = PH_MID;
                step_q.push_back(bus_result(K_READ, probe_addr, 1'b1, 8'h00, 1'b0));
            end
            OP_REPLY: begin
                a = probe_addr;
                if (srch_phase == PH_MID) begin
                    probe_byte = rq.reply_byte;
                    srch_phase = PH_LOW;
                    step_q.push_back(bus_result(K_READ, (a - 2) & ADDR_MASK, 1'b1, 8'h00,
                                                1'b0));
                end else if (srch_phase == PH_LOW) begin
                    found = 1'b0;
                    if (probe_byte == BYTE_ERASED && rq.reply_byte != BYTE_ERASED) begin
                        found = 1'b1;
                    end else if (probe_byte == BYTE_ERASED && a > LOG_START) begin
                        srch_hi = ADDR_W'(a & 32'hFFFF_FFFE);
                    end else if (a <= LOG_START) begin
                        a = LOG_START;
                        found = 1'b1;
                    end else begin
                        srch_lo = ADDR_W'(a & 32'hFFFF_FFFE);
                    end
                    if (a >= LOG_END - RECORD_BYTES) begin
                        found = 1'b1;
                    end
                    if (!found) begin
                        m = window_mid(srch_lo, srch_hi);
                        // A midpoint that repeats means the window can shrink no further.
                        if (m == a) begin
                            found = 1'b1;
                        end else begin
                            probe_addr = ADDR_W'(m);
                            srch_phase = PH_MID;
                            step_q.push_back(bus_result(K_READ, m, 1'b1, 8'h00, 1'b0));
                        end
                    end
                    if (found) begin
                        a = a & 32'hFFFF_FFF8;
                        if (a <= LOG_START) begin
                            a = LOG_START;
                        end
                        write_ptr = ADDR_W'(a);
                        probe_addr = ADDR_W'(a);
                        srch_phase = PH_IDLE;
                        step_q.push_back(bus_result(K_RECOVERED, 0, 1'b0, 8'h00, 1'b0));
                    end
                end
                // A reply while idle is dropped without any result.
            end
            OP_LOG: begin
                act = {rq.activity[15:1], rq.range_flag};
                rec[0] = capped_high(rq.red);
                rec[1] = rq.red[7:0];
                rec[2] = capped_high(rq.green);
                rec[3] = rq.green[7:0];
                rec[4] = capped_high(rq.blue);
                rec[5] = rq.blue[7:0];
                rec[6] = capped_high(act);
                rec[7] = act[7:0];
                p = (int'(period_setting) / PERIOD_STEP) * PERIOD_STEP;
                if (p < PERIOD_STEP) begin
                    p = PERIOD_STEP;
                end
                interval = BATTERY_SPAN / p;
                if (interval == 0) begin
                    interval = 1;
                end
                hour = ((int'(write_ptr) % interval) == 0);
                do_record = 1'b1;
            end
            default: begin
                for (int i = 0; i < RECORD_BYTES; i++) begin
                    rec[i] = MARK_RECORD[REC_W - 1 - 8 * i -: 8];
                end
                do_record = 1'b1;
            end
        endcase
        if (do_record) begin
            wp = write_ptr;
            if (wp + RECORD_BYTES > LOG_END) begin
                step_q.push_back(bus_result(K_FULL, 0, 1'b0, 8'h00, 1'b0));
            end else begin
                for (int i = 0; i < RECORD_BYTES; i++) begin
                    step_q.push_back(bus_result(K_WRITE, wp + i, 1'b1, rec[i],
                                                (i == 0) ? hour : 1'b0));
                end
                write_ptr = ADDR_W'((wp + RECORD_BYTES) & ADDR_MASK);
            end
        end
        foreach (step_q[i]) begin
            step_q[i].pointer = write_ptr;
            step_q[i].last = (i == step_q.size() - 1);
            result_q.push_back(step_q[i]);
        end
    endtask

    // Sample values lean toward the cases that matter: all-ones high bytes and extremes.
    function automatic logic [15:0] sample_value();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {BYTE_ERASED, 8'($urandom)};
            3: return {BYTE_CAPPED, 8'($urandom)};
            4: return {8'($urandom), 8'hFF};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_request make_request(input t_op op);
        t_request rq;
        rq.op = op;
        rq.reply_byte = ($urandom_range(0, 1) == 1) ? BYTE_ERASED : 8'($urandom);
        rq.red = sample_value();
        rq.green = sample_value();
        rq.blue = sample_value();
        rq.activity = sample_value();
        rq.range_flag = 1'($urandom);
        rq.from_memory = 1'b0;
        rq.erased_from = 0;
        return rq;
    endfunction

    // Short directed opening: field extremes, each operation and the named corner cases.
    task automatic queue_directed();
        t_request rq;
        // Reply with no search running: it must vanish.
        rq = make_request(OP_REPLY);
        rq.reply_byte = BYTE_ERASED;
        request_q.push_back(rq);
        // Logs starting at pointer zero with capped and uncapped high bytes and both range flags.
        rq = make_request(OP_LOG);
        rq.red = 16'hFFFF;
        rq.green = 16'h0000;
        rq.blue = 16'hFF00;
        rq.activity = 16'hFFFF;
        rq.range_flag = 1'b0;
        request_q.push_back(rq);
        rq.red = 16'h00FF;
        rq.green = 16'hFFFF;
        rq.blue = 16'hFEFF;
        rq.activity = 16'h0000;
        rq.range_flag = 1'b1;
        request_q.push_back(rq);
        request_q.push_back(make_request(OP_MARK));
        // Start twice, then an erased midpoint over a written byte ends the search at once.
        request_q.push_back(make_request(OP_START));
        request_q.push_back(make_request(OP_START));
        rq = make_request(OP_REPLY);
        rq.reply_byte = BYTE_ERASED;
        request_q.push_back(rq);
        rq.reply_byte = 8'h00;
        request_q.push_back(rq);
        // The pointer now lies in the second device.
        request_q.push_back(make_request(OP_LOG));
        // Log and mark while a search is open, then the search carries on.
        request_q.push_back(make_request(OP_START));
        rq = make_request(OP_REPLY);
        rq.reply_byte = 8'h00;
        request_q.push_back(rq);
        request_q.push_back(make_request(OP_LOG));
        request_q.push_back(make_request(OP_MARK));
        rq.reply_byte = 8'h7F;
        request_q.push_back(rq);
        // A fully erased log drives the search down to the log start and clamps there.
        request_q.push_back(make_request(OP_START));
        for (int i = 0; i < PROBE_REPLIES; i++) begin
            rq = make_request(OP_REPLY);
            rq.from_memory = 1'b1;
            rq.erased_from = 0;
            request_q.push_back(rq);
        end
    endtask

    // Random part: mostly complete recoveries against a modeled memory image with log and
    // mark traffic, some stray replies and restarts to break the sequence now and then.
    task automatic queue_random(input int unsigned units);
        t_request    rq;
        int unsigned made;
        int unsigned pick;
        int unsigned n;
        int unsigned erased_from;
        made = 0;
        while (made < units) begin
            pick = $urandom_range(0, 19);
            if (pick < 6) begin
                case ($urandom_range(0, 9))
                    0: erased_from = 0;
                    1: erased_from = LOG_START;
                    2: erased_from = LOG_START + RECORD_BYTES;
                    3: erased_from = LOG_END;
                    4: erased_from = LOG_END - RECORD_BYTES;
                    5: erased_from = DEV1_BASE;
                    6: erased_from = $urandom_range(LOG_START, LOG_END);
                    default: erased_from = RECORD_BYTES *
                        $urandom_range(LOG_START / RECORD_BYTES, LOG_END / RECORD_BYTES);
                endcase
                request_q.push_back(make_request(OP_START));
                for (int i = 0; i < PROBE_REPLIES; i++) begin
                    case ($urandom_range(0, 39))
                        0: request_q.push_back(make_request(OP_LOG));
                        1: request_q.push_back(make_request(OP_MARK));
                        2: request_q.push_back(make_request(OP_REPLY));
                        3: request_q.push_back(make_request(OP_START));
                        default: ;
                    endcase
                    rq = make_request(OP_REPLY);
                    rq.from_memory = 1'b1;
                    rq.erased_from = erased_from;
                    request_q.push_back(rq);
                end
                // A few records right after recovery; near the end of the log they hit full.
                n = $urandom_range(0, 3);
                repeat (n) request_q.push_back(make_request(OP_LOG));
                made += 30;
            end else if (pick < 15) begin
                n = $urandom_range(1, 6);
                repeat (n) request_q.push_back(make_request(OP_LOG));
                made += n;
            end else if (pick < 17) begin
                request_q.push_back(make_request(OP_MARK));
                made += 1;
            end else if (pick < 19) begin
                request_q.push_back(make_request(OP_REPLY));
            end else begin
                request_q.push_back(make_request(OP_START));
                made += 1;
            end
        end
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at the edge
    // where psel, penable, pwrite and pready are all high.
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_LOG_PERIOD;
        pwdata <= {17'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        period_setting = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until every request is in and every result is out, then let in-flight work settle.
    task automatic wait_quiet();
        while (request_q.size() != 0 || req_ch.valid || result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver. It changes inputs at the falling edge only, holds a request until it
    // is taken, and inserts random idle bursts between requests. Memory replies read the shadow
    // search state here, which by now reflects every accepted request.
    always @(negedge i_clk) begin
        t_request    nxt;
        bit          offer;
        bit          found_item;
        int unsigned rd_addr;
        offer = req_ch.valid;
        if (!req_ch.valid || req_fire) begin
            offer = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
            end else if (send_odds != 0 && request_q.size() != 0 &&
                         $urandom_range(0, 15) < send_odds) begin
                send_gap = $urandom_range(0, 7);
            end else begin
                found_item = 1'b0;
                // Memory replies left over once a search has ended are simply dropped.
                while (!found_item && request_q.size() != 0) begin
                    nxt = request_q.pop_front();
                    found_item = !(nxt.from_memory && srch_phase == PH_IDLE);
                end
                if (found_item) begin
                    if (nxt.from_memory) begin
                        rd_addr = (srch_phase == PH_MID) ? int'(probe_addr)
                                                         : (int'(probe_addr) - 2) & ADDR_MASK;
                        nxt.reply_byte = (rd_addr >= nxt.erased_from)
                                         ? BYTE_ERASED : 8'($urandom_range(0, 254));
                    end
                    held_req = nxt;
                    offer = 1'b1;
                end
            end
        end
        req_ch.valid <= offer;
        if (offer) begin
            req_ch.operation <= held_req.op;
            req_ch.read_byte <= held_req.reply_byte;
            req_ch.red <= held_req.red;
            req_ch.green <= held_req.green;
            req_ch.blue <= held_req.blue;
            req_ch.activity <= held_req.activity;
            req_ch.range_flag <= held_req.range_flag;
        end
    end

    // Result receiver. Ready drops in random bursts; once per run, when armed, it holds off
    // for a long stretch so that the writer backs up and stalls its request side.
    always @(negedge i_clk) begin
        bit take;
        take = 1'b1;
        if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            take = 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            take = 1'b0;
        end else if (recv_odds != 0 && $urandom_range(0, 15) < recv_odds) begin
            recv_gap = $urandom_range(0, 7);
            take = 1'b0;
        end
        res_ch.ready <= take;
    end

    // Monitor. Both channels are sampled at the rising edge: an accepted request advances
    // the shadow writer, an accepted result is checked against the oldest one owed.
    always @(posedge i_clk) begin
        t_request    taken;
        t_bus_result got;
        t_bus_result want;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            write_ptr = '0;
            srch_lo = ADDR_W'(LOG_START);
            srch_hi = ADDR_W'(LOG_END);
            probe_addr = '0;
            probe_byte = '0;
            srch_phase = PH_IDLE;
        end else begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                taken.op = t_op'(req_ch.operation);
                taken.reply_byte = req_ch.read_byte;
                taken.red = req_ch.red;
                taken.green = req_ch.green;
                taken.blue = req_ch.blue;
                taken.activity = req_ch.activity;
                taken.range_flag = req_ch.range_flag;
                taken.from_memory = 1'b0;
                taken.erased_from = 0;
                advance_writer(taken);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.kind = t_kind'(res_ch.kind);
                got.device = res_ch.bus_device;
                got.offset = res_ch.bus_offset;
                got.data = res_ch.write_data;
                got.hour_due = res_ch.hour_due;
                got.pointer = res_ch.pointer;
                got.last = res_ch.last;
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected result: %s", show(got));
                    end
                end else begin
                    want = result_q.pop_front();
                    if (got.kind !== want.kind || got.device !== want.device ||
                        got.offset !== want.offset || got.data !== want.data ||
                        got.hour_due !== want.hour_due || got.pointer !== want.pointer ||
                        got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("mismatch: expected %s", show(want));
                            $display("          actual   %s", show(got));
                        end
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Sequencer: reset, then one phase per period setting. Each phase writes the period while
    // the writer is idle, queues its requests and waits for every result before moving on.
    initial begin
        logic [PERIOD_W-1:0] period;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_START;
        req_ch.read_byte = '0;
        req_ch.red = '0;
        req_ch.green = '0;
        req_ch.blue = '0;
        req_ch.activity = '0;
        req_ch.range_flag = 1'b0;
        res_ch.ready = 1'b0;
        send_odds = 0;
        recv_odds = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_odds = SEND_ODDS[ph];
            recv_odds = RECV_ODDS[ph];
            period = (ph == RANDOM_PERIOD) ? PERIOD_W'($urandom) : PHASE_PERIODS[ph];
            write_period(period);
            if (ph == 0) begin
                queue_directed();
            end
            if (ph == HOLD_PHASE) begin
                hold_armed = 1'b1;
            end
            queue_random(PHASE_UNITS);
            // The sequencer pauses here until every owed result has come back.
            wait_quiet();
        end
        if (fail_count == 0 && result_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
